### hdl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16LE to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // Default width of the unit and byte counters.
  localparam int COUNT_WIDTH_DEF = 16;

  // Most results that one code unit can cause.
  localparam int MAX_RES = 4;

  // UTF-8 lead and continuation markers.
  localparam logic [7:0] CONT_MARK = 8'h80;
  localparam logic [7:0] LEAD2     = 8'hC0;
  localparam logic [7:0] LEAD3     = 8'hE0;
  localparam logic [7:0] LEAD4     = 8'hF0;

  // Offset added to a surrogate pair's payload.
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Surrogate ranges by the top six bits of a code unit.
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LONE_LOW = 2'd1,
    ST_NO_LOW   = 2'd2,
    ST_CUT_END  = 2'd3
  } status_t;

  // Decoder state carried from one word to the next.
  typedef struct packed {
    logic       held_valid;
    logic [9:0] held_high;
    logic       halted;
  } ctl_state_t;

  // All results caused by one word, handed to the serializer.
  typedef struct packed {
    logic [2:0]             cnt;
    logic [3:0][7:0]        bytes;
    status_t                status;
    logic [15:0]            units;
    logic [3:0][15:0]       bw;
  } res_bundle_t;

endpackage

### hdl/u16u8_decode.sv
// ----------------------------------------------------------------------------
// u16u8_decode
// Combinational decode of one UTF-16 code unit into its UTF-8 results and
// the next decoder state and counter values.
// ----------------------------------------------------------------------------
module u16u8_decode #(
  parameter int COUNT_WIDTH = u16u8_pkg::COUNT_WIDTH_DEF
) (
  input  logic [15:0]              code_unit,
  input  logic                     end_of_buffer,
  input  u16u8_pkg::ctl_state_t    cur,
  input  logic [COUNT_WIDTH-1:0]   unit_count,
  input  logic [COUNT_WIDTH-1:0]   byte_count,
  output u16u8_pkg::ctl_state_t    nxt,
  output logic [COUNT_WIDTH-1:0]   unit_count_nxt,
  output logic [COUNT_WIDTH-1:0]   byte_count_nxt,
  output u16u8_pkg::res_bundle_t   res
);
  import u16u8_pkg::*;

  // Saturating add of a small increment.
  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [2:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {{(COUNT_WIDTH-2){1'b0}}, b};
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  // Counter value as seen on a 16-bit port, clamped when it does not fit.
  function automatic logic [15:0] view16(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+15:0] e;
    e = {16'b0, v};
    return (|e[COUNT_WIDTH+15:16]) ? 16'hFFFF : e[15:0];
  endfunction

  logic        is_low;
  logic        is_high;
  logic [20:0] cp;
  logic [2:0]  nbytes;
  logic [2:0]  uinc;
  status_t     err;

  assign is_low  = (code_unit[15:10] == LOW_SURR_TAG);
  assign is_high = (code_unit[15:10] == HIGH_SURR_TAG);
  assign cp      = {1'b0, cur.held_high, code_unit[9:0]} + SUPP_BASE;

  // Classify the unit and build its bytes.
  always_comb begin
    nxt       = cur;
    nbytes    = 3'd0;
    uinc      = 3'd0;
    err       = ST_OK;
    res.bytes = '0;
    if (!cur.halted) begin
      priority if (cur.held_valid) begin
        if (is_low) begin
          nxt.held_valid = 1'b0;
          uinc           = 3'd2;
          nbytes         = 3'd4;
          res.bytes[0]   = LEAD4 | {5'b0, cp[20:18]};
          res.bytes[1]   = CONT_MARK | {2'b0, cp[17:12]};
          res.bytes[2]   = CONT_MARK | {2'b0, cp[11:6]};
          res.bytes[3]   = CONT_MARK | {2'b0, cp[5:0]};
        end else begin
          err = ST_NO_LOW;
        end
      end else if (is_high) begin
        if (end_of_buffer) begin
          err = ST_CUT_END;
        end else begin
          nxt.held_valid = 1'b1;
          nxt.held_high  = code_unit[9:0];
        end
      end else if (is_low) begin
        err = ST_LONE_LOW;
      end else if (code_unit[15:7] == 9'd0) begin
        uinc         = 3'd1;
        nbytes       = 3'd1;
        res.bytes[0] = code_unit[7:0];
      end else if (code_unit[15:11] == 5'd0) begin
        uinc         = 3'd1;
        nbytes       = 3'd2;
        res.bytes[0] = LEAD2 | {3'b0, code_unit[10:6]};
        res.bytes[1] = CONT_MARK | {2'b0, code_unit[5:0]};
      end else begin
        uinc         = 3'd1;
        nbytes       = 3'd3;
        res.bytes[0] = LEAD3 | {4'b0, code_unit[15:12]};
        res.bytes[1] = CONT_MARK | {2'b0, code_unit[11:6]};
        res.bytes[2] = CONT_MARK | {2'b0, code_unit[5:0]};
      end
    end

    unit_count_nxt = sat_add(unit_count, uinc);
    byte_count_nxt = sat_add(byte_count, nbytes);
    res.units      = view16(unit_count_nxt);
    for (int k = 0; k < MAX_RES; k++) begin
      res.bw[k] = view16(sat_add(byte_count, 3'(k + 1)));
    end

    // An error gives one result with the counters as they stood, and halts.
    if (err != ST_OK) begin
      res.cnt        = 3'd1;
      res.status     = err;
      res.bytes      = '0;
      res.bw[0]      = view16(byte_count);
      nxt.halted     = 1'b1;
      nxt.held_valid = 1'b0;
      nxt.held_high  = '0;
    end else begin
      res.cnt    = nbytes;
      res.status = ST_OK;
    end

    // The end-of-buffer mark clears everything after its results.
    if (end_of_buffer) begin
      nxt            = '0;
      unit_count_nxt = '0;
      byte_count_nxt = '0;
    end
  end

endmodule

### hdl/u16u8_serial.sv
// ----------------------------------------------------------------------------
// u16u8_serial
// Holds the results of one word and hands them out one byte per cycle
// through the output register, pausing while out_stall holds a byte.
// ----------------------------------------------------------------------------
module u16u8_serial (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_vld,
  input  u16u8_pkg::res_bundle_t load_res,
  output logic                   load_rdy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last_byte,
  output u16u8_pkg::status_t     out_status,
  output logic [15:0]            out_units_done,
  output logic [15:0]            out_bytes_written
);
  import u16u8_pkg::*;

  res_bundle_t buf_r;
  logic [2:0]  rem_r;
  logic [1:0]  ptr_r;
  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic        last_r;
  status_t     status_r;
  logic [15:0] units_r;
  logic [15:0] bw_r;

  logic out_load;
  logic pop;
  logic take;

  // The output register is free when empty or being taken.
  assign out_load = !out_valid_r || !out_stall;
  assign pop      = (rem_r != 3'd0) && out_load;
  assign load_rdy = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_load);
  assign take     = load_vld && load_rdy;

  // Result buffer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      ptr_r <= 2'd0;
    end else if (take) begin
      rem_r <= load_res.cnt;
      ptr_r <= 2'd0;
    end else if (pop) begin
      rem_r <= rem_r - 3'd1;
      ptr_r <= ptr_r + 2'd1;
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (take) begin
      buf_r <= load_res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r   <= buf_r.bytes[ptr_r];
      last_r   <= (rem_r == 3'd1);
      status_r <= buf_r.status;
      units_r  <= buf_r.units;
      bw_r     <= buf_r.bw[ptr_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = byte_r;
  assign out_last_byte     = last_r;
  assign out_status        = status_r;
  assign out_units_done    = units_r;
  assign out_bytes_written = bw_r;

endmodule

### hdl/utf16le_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder
// Converts UTF-16 code units to UTF-8 bytes, pairing surrogates, flagging
// encoding errors and keeping saturating unit and byte counts per buffer.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------
//   in      | input     | in_valid / in_stall   | code_unit, end_of_buffer
//   out     | output    | out_valid / out_stall | byte, last, status, counts
//
// One result byte leaves per cycle while out_stall is low; a word has zero
// to four results, and the next word is loaded as the last byte of the
// previous one leaves. A word passes the input register, the result buffer
// and the output register before its first byte appears.
// Reset (rst_n low, synchronous) empties all stages and clears the state.
// A stalled output holds its byte; the result buffer and the input register
// then fill and in_stall rises.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_transcoder #(
  parameter int COUNT_WIDTH = u16u8_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_code_unit,
  input  logic                in_end_of_buffer,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_last_byte,
  output u16u8_pkg::status_t  out_status,
  output logic [15:0]         out_units_done,
  output logic [15:0]         out_bytes_written
);
  import u16u8_pkg::*;

  logic                   in_vld_r;
  logic [15:0]            unit_r;
  logic                   eob_r;
  ctl_state_t             st_r;
  ctl_state_t             st_nxt;
  logic [COUNT_WIDTH-1:0] unit_count_r;
  logic [COUNT_WIDTH-1:0] unit_count_nxt;
  logic [COUNT_WIDTH-1:0] byte_count_r;
  logic [COUNT_WIDTH-1:0] byte_count_nxt;
  res_bundle_t            res;
  logic                   load_rdy;
  logic                   take;
  logic                   accept;

  // Input register: takes a word whenever it is empty or being drained.
  assign take     = in_vld_r && load_rdy;
  assign in_stall = in_vld_r && !load_rdy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (take) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unit_r <= in_code_unit;
      eob_r  <= in_end_of_buffer;
    end
  end

  // Decoder state and counters advance as the word moves to the serializer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      unit_count_r <= '0;
      byte_count_r <= '0;
    end else if (take) begin
      st_r         <= st_nxt;
      unit_count_r <= unit_count_nxt;
      byte_count_r <= byte_count_nxt;
    end
  end

  u16u8_decode #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_decode (
    .code_unit      (unit_r),
    .end_of_buffer  (eob_r),
    .cur            (st_r),
    .unit_count     (unit_count_r),
    .byte_count     (byte_count_r),
    .nxt            (st_nxt),
    .unit_count_nxt (unit_count_nxt),
    .byte_count_nxt (byte_count_nxt),
    .res            (res)
  );

  u16u8_serial u_serial (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_vld          (in_vld_r),
    .load_res          (res),
    .load_rdy          (load_rdy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_byte     (out_last_byte),
    .out_status        (out_status),
    .out_units_done    (out_units_done),
    .out_bytes_written (out_bytes_written)
  );

  // An error result is a single zero byte that closes its word.
  a_err_single : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_last_byte && out_byte == 8'd0))
    else $error("error result is not a single zero byte");

  // A halted decoder never holds a high surrogate.
  a_halt_no_held : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.halted |-> !st_r.held_valid)
    else $error("halted decoder holds a surrogate");

  // A held high surrogate followed by anything but a low one halts the block, unless it ends the buffer.
  a_broken_pair : assert property (@(posedge clk) disable iff (!rst_n)
    (take && st_r.held_valid && !st_r.halted && unit_r[15:10] != LOW_SURR_TAG
     && !eob_r) |=> st_r.halted)
    else $error("broken surrogate pair did not halt");

endmodule

### test/utf16le_to_utf8_transcoder_tb.sv
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder_tb
// Self-checking bench for the UTF-16 to UTF-8 transcoder. A queue-fed driver
// sends code units in bursts. The receiver stalls in changing patterns. A
// predictor kept in step with every accepted word supplies the expected
// bytes, and the monitor compares each result with them field by field.
// Stimulus covers directed encodings and errors, random buffers and one
// longer buffer of surrogate pairs sent back to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf16le_to_utf8_transcoder_tb;
  import u16u8_pkg::*;

  // Upper bounds of the one-byte and two-byte UTF-8 ranges.
  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [15:0] COUNT_SAT      = 16'hFFFF;

  // Timeout in clock cycles and the quiet time allowed at the end.
  localparam int RUN_LIMIT   = 3_000_000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  // Pairs in the longer buffer that is sent back to back.
  localparam int LONG_PAIRS = 8;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // One entry of the stimulus queue; a pause entry holds the sender back
  // until every expected byte has been received.
  typedef struct {
    logic [15:0] code;
    logic        eob;
    bit          calm;
    bit          pause;
  } unit_req_t;

  // One expected result.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    status_t     status;
    logic [15:0] units;
    logic [15:0] nbytes;
  } utf8_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_code_unit;
  logic        in_end_of_buffer;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last_byte;
  status_t     out_status;
  logic [15:0] out_units_done;
  logic [15:0] out_bytes_written;

  unit_req_t unit_feed_q[$];
  utf8_res_t utf8_due_q[$];

  // Predictor state.
  logic        hold_valid;
  logic [9:0]  hold_high;
  logic        is_halted;
  logic [15:0] unit_tally;
  logic [15:0] byte_tally;

  int unsigned cycle_cnt;
  int unsigned units_queued;
  int unsigned units_taken;
  int unsigned bytes_checked;
  int unsigned errors_checked;
  int unsigned mismatch_cnt;
  bit          in_fire;
  bit          units_sat_seen;
  bit          bytes_sat_seen;

  int          burst_left;
  int          gap_left;
  stall_mode_t stall_mode;
  int          stall_left;

  utf16le_to_utf8_transcoder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_code_unit      (in_code_unit),
    .in_end_of_buffer  (in_end_of_buffer),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_byte     (out_last_byte),
    .out_status        (out_status),
    .out_units_done    (out_units_done),
    .out_bytes_written (out_bytes_written)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Counter addition that sticks at the all-ones value.
  function automatic logic [15:0] sat_inc(input logic [15:0] a, input int unsigned b);
    logic [16:0] s;
    s = {1'b0, a} + b[16:0];
    return s[16] ? COUNT_SAT : s[15:0];
  endfunction

  // Failure bookkeeping; only the first few are printed.
  task automatic flag_error(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // Works out the results of one accepted code unit and queues them.
  task automatic transcode_unit(input logic [15:0] cu, input logic eob);
    logic [7:0]  seq [4];
    logic [20:0] cp;
    status_t     err;
    bit          lo_surr;
    bit          hi_surr;
    utf8_res_t   r;
    int          n;
    int          k;
    n = 0;
    err = ST_OK;
    lo_surr = (cu[15:10] == LOW_SURR_TAG);
    hi_surr = (cu[15:10] == HIGH_SURR_TAG);
    if (!is_halted) begin
      if (hold_valid) begin
        // A held high surrogate must be followed by a low one.
        if (lo_surr) begin
          cp = SUPP_BASE + {1'b0, hold_high, cu[9:0]};
          hold_valid = 1'b0;
          unit_tally = sat_inc(unit_tally, 2);
          seq[0] = LEAD4 | {5'b0, cp[20:18]};
          seq[1] = CONT_MARK | {2'b0, cp[17:12]};
          seq[2] = CONT_MARK | {2'b0, cp[11:6]};
          seq[3] = CONT_MARK | {2'b0, cp[5:0]};
          n = 4;
        end else begin
          err = ST_NO_LOW;
        end
      end else if (hi_surr) begin
        if (eob) begin
          err = ST_CUT_END;
        end else begin
          hold_high = cu[9:0];
          hold_valid = 1'b1;
        end
      end else if (lo_surr) begin
        err = ST_LONE_LOW;
      end else begin
        // Plain BMP unit: one, two or three bytes.
        unit_tally = sat_inc(unit_tally, 1);
        if (cu < ONE_BYTE_LIMIT) begin
          seq[0] = cu[7:0];
          n = 1;
        end else if (cu < TWO_BYTE_LIMIT) begin
          seq[0] = LEAD2 | {3'b0, cu[10:6]};
          seq[1] = CONT_MARK | {2'b0, cu[5:0]};
          n = 2;
        end else begin
          seq[0] = LEAD3 | {4'b0, cu[15:12]};
          seq[1] = CONT_MARK | {2'b0, cu[11:6]};
          seq[2] = CONT_MARK | {2'b0, cu[5:0]};
          n = 3;
        end
      end

      // An error gives a single result with the counts left untouched.
      if (err != ST_OK) begin
        r.data = 8'h00;
        r.last = 1'b1;
        r.status = err;
        r.units = unit_tally;
        r.nbytes = byte_tally;
        utf8_due_q.push_back(r);
        is_halted = 1'b1;
        hold_valid = 1'b0;
        hold_high = '0;
      end

      for (k = 0; k < n; k++) begin
        byte_tally = sat_inc(byte_tally, 1);
        r.data = seq[k];
        r.last = (k == n - 1);
        r.status = ST_OK;
        r.units = unit_tally;
        r.nbytes = byte_tally;
        utf8_due_q.push_back(r);
      end
    end

    // The end of a buffer clears everything once its results are out.
    if (eob) begin
      hold_valid = 1'b0;
      hold_high = '0;
      is_halted = 1'b0;
      unit_tally = '0;
      byte_tally = '0;
    end
  endtask

  task automatic queue_unit(input logic [15:0] code, input logic eob, input bit calm);
    unit_req_t q;
    q.code = code;
    q.eob = eob;
    q.calm = calm;
    q.pause = 1'b0;
    unit_feed_q.push_back(q);
    units_queued++;
  endtask

  task automatic queue_pause();
    unit_req_t q;
    q.code = '0;
    q.eob = 1'b0;
    q.calm = 1'b0;
    q.pause = 1'b1;
    unit_feed_q.push_back(q);
  endtask

  // Random non-surrogate unit that needs three bytes.
  function automatic logic [15:0] rand_bmp3();
    logic [15:0] c;
    c = 16'($urandom_range(16'h0800, 16'hF7FF));
    if (c >= 16'hD800) begin
      c = c + 16'h0800;
    end
    return c;
  endfunction

  function automatic logic [15:0] rand_high();
    return {HIGH_SURR_TAG, 10'($urandom_range(0, 1023))};
  endfunction

  function automatic logic [15:0] rand_low();
    return {LOW_SURR_TAG, 10'($urandom_range(0, 1023))};
  endfunction

  // Checks the result side and feeds accepted words to the predictor.
  always @(posedge clk) begin : check_and_predict
    utf8_res_t want;
    cycle_cnt++;
    in_fire = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (out_status == ST_OK) begin
          bytes_checked++;
        end else begin
          errors_checked++;
        end
        if (out_units_done == COUNT_SAT) begin
          units_sat_seen = 1'b1;
        end
        if (out_bytes_written == COUNT_SAT) begin
          bytes_sat_seen = 1'b1;
        end
        if (utf8_due_q.size() == 0) begin
          flag_error($sformatf("unexpected byte %02h last %0b status %0d units %0d bytes %0d",
                               out_byte, out_last_byte, out_status, out_units_done,
                               out_bytes_written));
        end else begin
          want = utf8_due_q.pop_front();
          if (out_byte !== want.data || out_last_byte !== want.last ||
              out_status !== want.status || out_units_done !== want.units ||
              out_bytes_written !== want.nbytes) begin
            flag_error($sformatf({"expected byte %02h last %0b status %0d units %0d bytes %0d,",
                                  " got byte %02h last %0b status %0d units %0d bytes %0d"},
                                 want.data, want.last, want.status, want.units, want.nbytes,
                                 out_byte, out_last_byte, out_status, out_units_done,
                                 out_bytes_written));
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_fire = 1'b1;
        units_taken++;
        transcode_unit(in_code_unit, in_end_of_buffer);
      end
    end
  end

  // Sender: bursts of words with random gaps, and pauses on request.
  always @(negedge clk) begin : drive_units
    unit_req_t nxt;
    if (rst_n) begin
      if (in_valid && !in_fire) begin
        // Stalled word stays on the bus unchanged.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (unit_feed_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (unit_feed_q[0].pause) begin
        in_valid <= 1'b0;
        if (utf8_due_q.size() == 0) begin
          nxt = unit_feed_q.pop_front();
        end
      end else begin
        nxt = unit_feed_q.pop_front();
        in_valid <= 1'b1;
        in_code_unit <= nxt.code;
        in_end_of_buffer <= nxt.eob;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left = nxt.calm ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: a new stall pattern is drawn whenever the current one runs out.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_LIGHT: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      STALL_HEAVY: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall <= (cycle_cnt % 3 == 0);
      end
    endcase
  end

  // Timeout.
  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
    end
    $display("Timeout after %0d cycles, %0d results still expected",
             cycle_cnt, utf8_due_q.size());
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int  len;
    int  k;
    int  pick;
    int  start_cnt;
    bit  calm;
    bit  last;
    bit  ended;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_code_unit = '0;
    in_end_of_buffer = 1'b0;
    out_stall = 1'b0;
    hold_valid = 1'b0;
    hold_high = '0;
    is_halted = 1'b0;
    unit_tally = '0;
    byte_tally = '0;
    cycle_cnt = 0;
    units_queued = 0;
    units_taken = 0;
    bytes_checked = 0;
    errors_checked = 0;
    mismatch_cnt = 0;
    in_fire = 1'b0;
    units_sat_seen = 1'b0;
    bytes_sat_seen = 1'b0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = STALL_NONE;
    stall_left = 0;

    // Directed: range boundaries of each encoding length.
    queue_unit(16'h0000, 1'b0, 1'b0);
    queue_unit(16'h007F, 1'b0, 1'b0);
    queue_unit(16'h0080, 1'b0, 1'b0);
    queue_unit(16'h07FF, 1'b0, 1'b0);
    queue_unit(16'h0800, 1'b0, 1'b0);
    queue_unit(16'hD7FF, 1'b0, 1'b0);
    queue_unit(16'hE000, 1'b0, 1'b0);
    queue_unit(16'hFFFF, 1'b1, 1'b0);
    // Lowest and highest surrogate pairs, the second ending the buffer.
    queue_unit(16'hD800, 1'b0, 1'b0);
    queue_unit(16'hDC00, 1'b0, 1'b0);
    queue_unit(16'hDBFF, 1'b0, 1'b0);
    queue_unit(16'hDFFF, 1'b1, 1'b0);
    // Lone low surrogate; the rest of the buffer is ignored.
    queue_unit(16'hDC00, 1'b0, 1'b0);
    queue_unit(16'h0041, 1'b0, 1'b0);
    queue_unit(16'hD800, 1'b0, 1'b0);
    queue_unit(16'h1234, 1'b1, 1'b0);
    // High surrogate followed by another high one.
    queue_unit(16'hD800, 1'b0, 1'b0);
    queue_unit(16'hD801, 1'b0, 1'b0);
    queue_unit(16'hFFFF, 1'b1, 1'b0);
    // High surrogate cut by the end of the buffer.
    queue_unit(16'hD812, 1'b1, 1'b0);
    // Broken pair on the last unit, and a lone low on the last unit.
    queue_unit(16'hD800, 1'b0, 1'b0);
    queue_unit(16'h0041, 1'b1, 1'b0);
    queue_unit(16'hDFFF, 1'b1, 1'b0);
    queue_pause();

    // Random buffers, mostly well formed, some with encoding errors.
    start_cnt = units_queued;
    while (units_queued - start_cnt < 165) begin
      len = $urandom_range(1, 10);
      calm = ($urandom_range(0, 4) == 0);
      ended = 1'b0;
      for (k = 0; k < len && !ended; k++) begin
        last = (k == len - 1);
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
          queue_unit(16'($urandom_range(0, 16'h007F)), last, calm);
        end else if (pick < 40) begin
          queue_unit(16'($urandom_range(16'h0080, 16'h07FF)), last, calm);
        end else if (pick < 60) begin
          queue_unit(rand_bmp3(), last, calm);
        end else if (pick < 82) begin
          queue_unit(rand_high(), 1'b0, calm);
          queue_unit(rand_low(), last, calm);
        end else if (pick < 87) begin
          queue_unit(rand_low(), last, calm);
        end else if (pick < 92) begin
          queue_unit(rand_high(), 1'b0, calm);
          queue_unit(($urandom_range(0, 1) == 1) ? rand_high() : rand_bmp3(), last, calm);
        end else if (pick < 95) begin
          queue_unit(rand_high(), 1'b1, calm);
          ended = 1'b1;
        end else begin
          queue_unit(16'($urandom_range(0, 16'hFFFF)), last, calm);
        end
      end
      if (units_queued - start_cnt > 80 && units_queued - start_cnt <= 90) begin
        queue_pause();
      end
    end
    queue_pause();

    // One longer buffer of surrogate pairs, sent without gaps.
    for (k = 0; k < LONG_PAIRS; k++) begin
      queue_unit(rand_high(), 1'b0, 1'b1);
      queue_unit(rand_low(), (k == LONG_PAIRS - 1), 1'b1);
    end
    // The counters must start over in the next buffer.
    queue_unit(16'h0041, 1'b0, 1'b0);
    queue_unit(16'h00E9, 1'b1, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (units_taken < units_queued || utf8_due_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d code units; checked %0d UTF-8 bytes and %0d error results.",
             units_taken, bytes_checked, errors_checked);
    $display("Counter saturation reached: units %0b, bytes %0b; mismatches %0d.",
             units_sat_seen, bytes_sat_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/u16u8_pkg.sv
hdl/u16u8_decode.sv
hdl/u16u8_serial.sv
hdl/utf16le_to_utf8_transcoder.sv
test/utf16le_to_utf8_transcoder_tb.sv
